// ----- rtl/core/pcta_pkg.sv -----
// shared types, constants and datapath commands of the pwm channel and timer allocator
`timescale 1ns / 1ps

package pcta_pkg;

    // default sizes of the allocator
    localparam int CHANNELS_PER_GROUP_DEF = 8;
    localparam int TIMERS_PER_GROUP_DEF   = 4;
    localparam int SPEED_GROUPS_DEF       = 2;
    localparam int FRACTION_BITS_DEF      = 16;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int PIN_W      = 6;
    localparam int FREQ_W     = 26;
    localparam int RES_W      = 5;
    localparam int DUTY_W     = 21;
    localparam int FRAC_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int CHAN_W     = 3;
    localparam int TMR_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 26;

    localparam logic [RES_W-1:0]  MAX_RES        = 5'd20;
    localparam logic [FREQ_W-1:0] DFLT_FREQ_RST  = 26'd50;
    localparam logic [RES_W-1:0]  DFLT_RES_RST   = 5'd16;

    // request codes
    localparam logic [ACTION_W-1:0] ACT_CONFIGURE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP      = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RES     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RESOURCE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DFLT_FREQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DFLT_RES  = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PIN_W-1:0]    pin;
        logic [FREQ_W-1:0]   frequency;
        logic [RES_W-1:0]    resolution;
        logic [DUTY_W-1:0]   duty_raw;
        logic [FRAC_W-1:0]   duty_fraction;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                speed_group;
        logic [CHAN_W-1:0]   channel;
        logic [TMR_W-1:0]    timer;
        logic                timer_new;
        logic [FREQ_W-1:0]   timer_frequency;
        logic [RES_W-1:0]    timer_resolution;
        logic [DUTY_W-1:0]   duty_out;
        logic                channel_found;
    } t_out_word;

    // commands from controller to datapath
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_START,
        OP_ALLOC_BEGIN,
        OP_CH_STEP,
        OP_CH_TAKE,
        OP_REF_STEP,
        OP_DROP_END,
        OP_TM_STEP,
        OP_CLAIM,
        OP_NEXT_GRP,
        OP_FAIL,
        OP_LOOK_STEP,
        OP_W_HIT,
        OP_DUTY,
        OP_STOP_FREE
    } t_dp_op;

    // status from datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                res_bad;
        logic                ch_hit;
        logic                have_c;
        logic                has_timer;
        logic                tm_hit;
        logic                have_t;
        logic                ch_last;
        logic                tm_last;
        logic                grp_last;
    } t_dp_status;

endpackage

// ----- rtl/core/pcta_ctrl.sv -----
// sequencing state machine of the pwm channel and timer allocator
`timescale 1ns / 1ps

module pcta_ctrl
    import pcta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_op     o_op,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOOK,
        S_W_HIT,
        S_ALLOC,
        S_CH,
        S_CH_DONE,
        S_DROP,
        S_DROP_END,
        S_TM,
        S_TM_DONE,
        S_DUTY,
        S_STOP_SCAN,
        S_STOP_FREE,
        S_STOP_NEXT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_op    = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_START;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_status.action)
                    ACT_CONFIGURE: n_state = S_ALLOC;
                    ACT_WRITE:     n_state = S_LOOK;
                    ACT_STOP:      n_state = S_STOP_SCAN;
                    default:       n_state = S_DONE;
                endcase
            end
            S_LOOK: begin
                o_op = OP_LOOK_STEP;
                if (i_status.ch_hit) begin
                    n_state = S_W_HIT;
                end else if (i_status.ch_last && i_status.grp_last) begin
                    n_state = S_ALLOC;
                end
            end
            S_W_HIT: begin
                o_op    = OP_W_HIT;
                n_state = i_status.has_timer ? S_DUTY : S_DONE;
            end
            S_ALLOC: begin
                o_op    = OP_ALLOC_BEGIN;
                n_state = i_status.res_bad ? S_DONE : S_CH;
            end
            S_CH: begin
                o_op = OP_CH_STEP;
                if (i_status.ch_hit || i_status.ch_last) begin
                    n_state = S_CH_DONE;
                end
            end
            S_CH_DONE: begin
                if (i_status.have_c) begin
                    o_op    = OP_CH_TAKE;
                    n_state = i_status.has_timer ? S_DROP : S_TM;
                end else if (i_status.grp_last) begin
                    o_op    = OP_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_NEXT_GRP;
                    n_state = S_CH;
                end
            end
            S_DROP: begin
                o_op = OP_REF_STEP;
                if (i_status.ch_last) begin
                    n_state = S_DROP_END;
                end
            end
            S_DROP_END: begin
                o_op    = OP_DROP_END;
                n_state = (i_status.action == ACT_STOP) ? S_STOP_NEXT : S_TM;
            end
            S_TM: begin
                o_op = OP_TM_STEP;
                if (i_status.tm_hit || i_status.tm_last) begin
                    n_state = S_TM_DONE;
                end
            end
            S_TM_DONE: begin
                if (i_status.have_t) begin
                    o_op    = OP_CLAIM;
                    n_state = (i_status.action == ACT_WRITE) ? S_DUTY : S_DONE;
                end else if (i_status.grp_last) begin
                    o_op    = OP_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_NEXT_GRP;
                    n_state = S_CH;
                end
            end
            S_DUTY: begin
                o_op    = OP_DUTY;
                n_state = S_DONE;
            end
            S_STOP_SCAN: begin
                o_op = OP_CH_STEP;
                if (i_status.ch_hit) begin
                    n_state = S_STOP_FREE;
                end else if (i_status.ch_last) begin
                    n_state = S_STOP_NEXT;
                end
            end
            S_STOP_FREE: begin
                o_op    = OP_STOP_FREE;
                n_state = i_status.has_timer ? S_DROP : S_STOP_NEXT;
            end
            S_STOP_NEXT: begin
                if (i_status.grp_last) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = OP_NEXT_GRP;
                    n_state = S_STOP_SCAN;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_done  <= (n_state == S_DONE);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// ----- rtl/core/pcta_dp.sv -----
// channel and timer tables, scan registers and duty arithmetic of the allocator
`timescale 1ns / 1ps

module pcta_dp
    import pcta_pkg::*;
#(
    parameter int CHANNELS_PER_GROUP = CHANNELS_PER_GROUP_DEF,
    parameter int TIMERS_PER_GROUP   = TIMERS_PER_GROUP_DEF,
    parameter int SPEED_GROUPS       = SPEED_GROUPS_DEF,
    parameter int FRACTION_BITS      = FRACTION_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_dp_op                i_op,
    output t_dp_status            o_status,
    output t_out_word             o_word
);

    localparam int CW = (CHANNELS_PER_GROUP > 1) ? $clog2(CHANNELS_PER_GROUP) : 1;
    localparam int TW = (TIMERS_PER_GROUP > 1) ? $clog2(TIMERS_PER_GROUP) : 1;
    localparam int GW = (SPEED_GROUPS > 1) ? $clog2(SPEED_GROUPS) : 1;
    localparam int IW = (CW > TW) ? CW : TW;
    localparam int FW = (FRAC_W > FRACTION_BITS + 1) ? FRAC_W : FRACTION_BITS + 1;
    localparam int DW = FW + 21;
    localparam logic [FW-1:0] FULL = {{(FW-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic [DW-1:0] HALF = {{(DW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

    // request and settings
    t_in_word          r_req;
    logic [FREQ_W-1:0] r_eff_freq;
    logic [RES_W-1:0]  r_eff_res;
    logic [FREQ_W-1:0] r_dflt_freq;
    logic [RES_W-1:0]  r_dflt_res;

    // scan registers
    logic [GW-1:0] r_grp;
    logic [IW-1:0] r_idx;
    logic          r_have_c;
    logic [CW-1:0] r_ch;
    logic          r_have_t;
    logic [TW-1:0] r_tm;
    logic [TW-1:0] r_old;
    logic          r_used;

    // channel and timer tables
    logic              r_ch_valid [SPEED_GROUPS][CHANNELS_PER_GROUP];
    logic [PIN_W-1:0]  r_ch_pin   [SPEED_GROUPS][CHANNELS_PER_GROUP];
    logic              r_ch_tv    [SPEED_GROUPS][CHANNELS_PER_GROUP];
    logic [TW-1:0]     r_ch_tidx  [SPEED_GROUPS][CHANNELS_PER_GROUP];
    logic              r_tm_valid [SPEED_GROUPS][TIMERS_PER_GROUP];
    logic [FREQ_W-1:0] r_tm_freq  [SPEED_GROUPS][TIMERS_PER_GROUP];
    logic [RES_W-1:0]  r_tm_res   [SPEED_GROUPS][TIMERS_PER_GROUP];

    t_out_word r_out;

    logic [CW-1:0]     ch_addr;
    logic [TW-1:0]     tm_addr;
    logic              ch_v;
    logic [PIN_W-1:0]  ch_p;
    logic              ch_tv;
    logic [TW-1:0]     ch_ti;
    logic              tm_v;
    logic [FREQ_W-1:0] tm_f;
    logic [RES_W-1:0]  tm_r;
    logic              ch_hit;
    logic              ref_hit;
    logic              tm_hit;
    logic              ch_last;
    logic              grp_last;
    logic [RES_W-1:0]  res_clamp;
    logic [FW-1:0]     frac_ext;
    logic [FW-1:0]     frac_sat;
    logic [DW-1:0]     duty_sum;
    logic [DUTY_W-1:0] duty_val;

    // one read address per table
    always_comb begin
        case (i_op)
            OP_CH_TAKE, OP_W_HIT, OP_CLAIM, OP_STOP_FREE: ch_addr = r_ch;
            default:                                      ch_addr = r_idx[CW-1:0];
        endcase
        case (i_op)
            OP_DROP_END:       tm_addr = r_old;
            OP_CLAIM, OP_DUTY: tm_addr = r_tm;
            default:           tm_addr = r_idx[TW-1:0];
        endcase
    end

    assign ch_v  = r_ch_valid[r_grp][ch_addr];
    assign ch_p  = r_ch_pin[r_grp][ch_addr];
    assign ch_tv = r_ch_tv[r_grp][ch_addr];
    assign ch_ti = r_ch_tidx[r_grp][ch_addr];
    assign tm_v  = r_tm_valid[r_grp][tm_addr];
    assign tm_f  = r_tm_freq[r_grp][tm_addr];
    assign tm_r  = r_tm_res[r_grp][tm_addr];

    assign ch_hit   = ch_v && (ch_p == r_req.pin);
    assign ref_hit  = ch_tv && (ch_ti == r_old);
    assign tm_hit   = tm_v && (tm_f == r_eff_freq) && (tm_r == r_eff_res);
    assign ch_last  = (r_idx == IW'(CHANNELS_PER_GROUP - 1));
    assign grp_last = (r_grp == GW'(SPEED_GROUPS - 1));

    // round half up of fraction times two to the resolution
    assign res_clamp = (tm_r > MAX_RES) ? MAX_RES : tm_r;
    assign frac_ext  = FW'(r_req.duty_fraction);
    assign frac_sat  = (frac_ext > FULL) ? FULL : frac_ext;
    assign duty_sum  = (DW'(frac_sat) << res_clamp) + HALF;
    assign duty_val  = duty_sum[FRACTION_BITS+DUTY_W-1:FRACTION_BITS];

    always_comb begin
        o_status.action    = r_req.action;
        o_status.res_bad   = (r_eff_res == '0) || (r_eff_res > MAX_RES);
        o_status.ch_hit    = ch_hit;
        o_status.have_c    = r_have_c;
        o_status.has_timer = ch_tv;
        o_status.tm_hit    = tm_hit;
        o_status.have_t    = r_have_t;
        o_status.ch_last   = ch_last;
        o_status.tm_last   = (r_idx == IW'(TIMERS_PER_GROUP - 1));
        o_status.grp_last  = grp_last;
    end

    // defaults used by write when the pin holds no channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_freq <= DFLT_FREQ_RST;
            r_dflt_res  <= DFLT_RES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DFLT_FREQ: r_dflt_freq <= i_cfg_wdata[FREQ_W-1:0];
                CFG_DFLT_RES:  r_dflt_res  <= i_cfg_wdata[RES_W-1:0];
                default:       r_dflt_res  <= r_dflt_res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_valid <= '{default: '0};
            r_ch_tv    <= '{default: '0};
            r_tm_valid <= '{default: '0};
            r_grp      <= '0;
            r_idx      <= '0;
            r_have_c   <= 1'b0;
            r_have_t   <= 1'b0;
            r_used     <= 1'b0;
        end else begin
            unique case (i_op)
                OP_START: begin
                    r_req      <= i_word;
                    r_eff_freq <= (i_word.action == ACT_WRITE) ? r_dflt_freq : i_word.frequency;
                    r_eff_res  <= (i_word.action == ACT_WRITE) ? r_dflt_res : i_word.resolution;
                    r_grp      <= '0;
                    r_idx      <= '0;
                    r_have_c   <= 1'b0;
                    r_have_t   <= 1'b0;
                    r_out      <= '0;
                end
                OP_ALLOC_BEGIN: begin
                    r_grp    <= '0;
                    r_idx    <= '0;
                    r_have_c <= 1'b0;
                    r_have_t <= 1'b0;
                    if (o_status.res_bad) begin
                        r_out.status <= ST_BAD_RES;
                    end
                end
                OP_CH_STEP: begin
                    // own channel wins, else the first free one
                    if (ch_hit || (!r_have_c && !ch_v)) begin
                        r_ch     <= r_idx[CW-1:0];
                        r_have_c <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                OP_CH_TAKE: begin
                    r_idx  <= '0;
                    r_used <= 1'b0;
                    if (ch_tv) begin
                        r_old                     <= ch_ti;
                        r_ch_tv[r_grp][ch_addr]   <= 1'b0;
                        r_ch_tidx[r_grp][ch_addr] <= '0;
                    end
                end
                OP_REF_STEP: begin
                    if (ref_hit) begin
                        r_used <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                OP_DROP_END: begin
                    if (!r_used) begin
                        r_tm_valid[r_grp][tm_addr] <= 1'b0;
                    end
                    r_idx <= '0;
                end
                OP_TM_STEP: begin
                    if (tm_hit || (!r_have_t && !tm_v)) begin
                        r_tm     <= r_idx[TW-1:0];
                        r_have_t <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                OP_CLAIM: begin
                    if (!tm_v) begin
                        r_tm_valid[r_grp][tm_addr] <= 1'b1;
                        r_tm_freq[r_grp][tm_addr]  <= r_eff_freq;
                        r_tm_res[r_grp][tm_addr]   <= r_eff_res;
                    end
                    r_ch_valid[r_grp][ch_addr] <= 1'b1;
                    r_ch_pin[r_grp][ch_addr]   <= r_req.pin;
                    r_ch_tv[r_grp][ch_addr]    <= 1'b1;
                    r_ch_tidx[r_grp][ch_addr]  <= r_tm;
                    r_out.status           <= ST_OK;
                    r_out.speed_group      <= r_grp[0];
                    r_out.channel          <= CHAN_W'(r_ch);
                    r_out.timer            <= TMR_W'(r_tm);
                    r_out.timer_new        <= !tm_v;
                    r_out.timer_frequency  <= r_eff_freq;
                    r_out.timer_resolution <= r_eff_res;
                    r_out.duty_out         <= r_req.duty_raw;
                end
                OP_NEXT_GRP: begin
                    r_grp    <= r_grp + 1'b1;
                    r_idx    <= '0;
                    r_have_c <= 1'b0;
                    r_have_t <= 1'b0;
                end
                OP_FAIL: begin
                    r_out.status <= ST_NO_RESOURCE;
                end
                OP_LOOK_STEP: begin
                    // walk every group for the pin's own channel
                    if (ch_hit) begin
                        r_ch     <= r_idx[CW-1:0];
                        r_have_c <= 1'b1;
                    end else if (ch_last) begin
                        r_idx <= '0;
                        if (!grp_last) begin
                            r_grp <= r_grp + 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                OP_W_HIT: begin
                    r_out.speed_group <= r_grp[0];
                    r_out.channel     <= CHAN_W'(r_ch);
                    if (ch_tv) begin
                        r_tm        <= ch_ti;
                        r_out.timer <= TMR_W'(ch_ti);
                    end else begin
                        r_out.status <= ST_NO_RESOURCE;
                    end
                end
                OP_DUTY: begin
                    r_out.duty_out         <= duty_val;
                    r_out.timer_frequency  <= tm_f;
                    r_out.timer_resolution <= tm_r;
                end
                OP_STOP_FREE: begin
                    r_old                      <= ch_ti;
                    r_ch_valid[r_grp][ch_addr] <= 1'b0;
                    r_ch_tv[r_grp][ch_addr]    <= 1'b0;
                    r_out.channel_found        <= 1'b1;
                    r_out.speed_group          <= r_grp[0];
                    r_out.channel              <= CHAN_W'(r_ch);
                    r_idx                      <= '0;
                    r_used                     <= 1'b0;
                end
                default: begin
                    r_used <= r_used;
                end
            endcase
        end
    end

    assign o_word = r_out;

endmodule

// ----- rtl/core/pwm_channel_timer_allocator.sv -----
// top level of the pwm channel and timer allocator: controller plus datapath
// configure checks the resolution, then per group scans the channels, releases the old timer
// if no other channel uses it, and scans the timers; write first seeks the pin in every group
// and allocates if none holds it, then works out the duty; stop frees the pin's channel in each group
// and its unused timer; one word at a time, next start taken the cycle after o_done
// sync active-low reset frees all channels and timers, restores defaults; results never stall
`timescale 1ns / 1ps

module pwm_channel_timer_allocator
    import pcta_pkg::*;
#(
    parameter int CHANNELS_PER_GROUP = CHANNELS_PER_GROUP_DEF,
    parameter int TIMERS_PER_GROUP   = TIMERS_PER_GROUP_DEF,
    parameter int SPEED_GROUPS       = SPEED_GROUPS_DEF,
    parameter int FRACTION_BITS      = FRACTION_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request word, taken when start is high and busy is low
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_word,
    // default settings write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // result word, valid from the single cycle o_done is high until the next request is taken
    output logic                  o_done,
    output t_out_word             o_word
);

    // command and status between sequencer and tables
    t_dp_op     dp_op;
    t_dp_status dp_status;

    pcta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_op     (dp_op),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // channel/timer tables; scans walk one entry a cycle under controller command
    pcta_dp #(
        .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP),
        .TIMERS_PER_GROUP   (TIMERS_PER_GROUP),
        .SPEED_GROUPS       (SPEED_GROUPS),
        .FRACTION_BITS      (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (dp_op),
        .o_status    (dp_status),
        .o_word      (o_word)
    );

endmodule

// ----- rtl/core/pcta_checker.sv -----
// port-level checks of the pwm channel and timer allocator, bound to the top level
`timescale 1ns / 1ps

module pcta_checker
    import pcta_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_word o_word
);

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // after the result the block returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result");

    // a rejected resolution carries no duty, no new timer and no timer frequency
    a_bad_res_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_word.status == ST_BAD_RES)) |->
        (o_word.duty_out == '0 && !o_word.timer_new && o_word.timer_frequency == '0))
        else $error("rejected resolution left fields set");

    // a newly claimed timer only comes with success and a legal resolution
    a_new_timer_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.timer_new) |->
        (o_word.status == ST_OK && o_word.timer_resolution != '0 &&
         o_word.timer_resolution <= MAX_RES))
        else $error("new timer with bad status or resolution");

endmodule

bind pwm_channel_timer_allocator pcta_checker u_checker (.*);
